/* rtl/acos_pkg.sv */
// shared constants and coefficient scaling for the arc cosine polynomial unit
`default_nettype none

package acos_pkg;

    // io format is q1.14 in, q2.14 out
    localparam int IO_FRAC = 14;
    localparam int ONE_IO = 16384;

    // default internal fraction width
    localparam int FRAC_BITS_DEF = 14;

    // coefficients and pi scaled by 2^30, rounded to nearest
    localparam logic [63:0] K30_C3 = 64'd20110433;
    localparam logic [63:0] K30_C2 = 64'd79737142;
    localparam logic [63:0] K30_C1 = 64'd227756103;
    localparam logic [63:0] K30_C0 = 64'd1686557207;
    localparam logic [63:0] K30_PI = 64'd3373259426;

    // scale a 2^30 constant down to frac fraction bits, round half up
    function automatic logic [63:0] to_frac(input logic [63:0] k30, input int frac);
        int sh;
        logic [63:0] half;
        sh = 30 - frac;
        if (sh == 0) begin
            return k30;
        end
        half = 64'd1 << (sh - 1);
        return (k30 + half) >> sh;
    endfunction

endpackage

`default_nettype wire

/* rtl/arc_cosine_polynomial_unit.sv */
// top level of the arc cosine polynomial unit
//
// usage: one q1.14 cosine value enters on i_x_value with i_valid/o_ready and
// its arc cosine leaves as unsigned q2.14 radians on o_angle with
// o_valid/i_ready. a transfer happens on each edge where valid and ready meet.
// values beyond +-1.0 saturate to the bound (angle 0 or pi).
// pipeline: FRAC_BITS + 7 register stages: one input stage, three horner
// cells, FRAC_BITS + 1 square root cells (one root digit per cell), one
// product stage and one output register.
// throughput: one item per cycle while the receiver is ready, each cell holding one item.
// when the receiver stalls, each cell keeps its item and an empty cell
// further up still takes data, so the chain fills before o_ready drops.
// reset clears every valid flag; the data registers are not reset.
`default_nettype none

module arc_cosine_polynomial_unit #(
    parameter int FRAC_BITS = acos_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_x_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic             [15:0] o_angle
);

    localparam int W  = FRAC_BITS + 1;
    localparam int N  = 2*FRAC_BITS + 2;
    localparam int NC = FRAC_BITS + 1;
    localparam int PW = W + 1;

    localparam logic [W-1:0]   ONE  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0]   C3   = W'(acos_pkg::to_frac(acos_pkg::K30_C3, FRAC_BITS));
    localparam logic [W:0]     PI   = (W+1)'(acos_pkg::to_frac(acos_pkg::K30_PI, FRAC_BITS));
    localparam logic [2*W:0]   HALF = (2*W+1)'(1) << (FRAC_BITS - 1);

    // ---------------- input stage ----------------
    logic           r_s0_valid;
    logic [W-1:0]   r_s0_a;
    logic           r_s0_neg;
    logic           w_s0_take;

    logic [15:0]    w_mag16;
    logic [14:0]    w_mag15;
    logic [W-1:0]   n_s0_a;

    // magnitude with saturation at 1.0
    assign w_mag16 = i_x_value[15] ? (~i_x_value + 16'd1) : i_x_value;
    assign w_mag15 = (w_mag16 > 16'(acos_pkg::ONE_IO)) ? 15'(acos_pkg::ONE_IO)
                                                         : w_mag16[14:0];

    // move magnitude to the internal fraction width
    generate
        if (FRAC_BITS > acos_pkg::IO_FRAC) begin : g_widen
            assign n_s0_a = {w_mag15, {(FRAC_BITS - acos_pkg::IO_FRAC){1'b0}}};
        end else if (FRAC_BITS == acos_pkg::IO_FRAC) begin : g_same
            assign n_s0_a = w_mag15;
        end else begin : g_narrow
            assign n_s0_a = w_mag15[14:acos_pkg::IO_FRAC-FRAC_BITS];
        end
    endgenerate

    logic           h_ready [3];
    logic           h_valid [3];
    logic [W-1:0]   h_acc   [3];
    logic [W-1:0]   h_a     [3];
    logic           h_neg   [3];

    assign w_s0_take = !r_s0_valid || h_ready[0];
    assign o_ready   = w_s0_take;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_s0_take) begin
            r_s0_valid <= i_valid;
        end
        if (w_s0_take && i_valid) begin
            r_s0_a   <= n_s0_a;
            r_s0_neg <= i_x_value[15];
        end
    end

    // ---------------- horner cells ----------------
    logic w_sq_ready [NC];

    acos_horner_cell #(
        .FRAC_BITS (FRAC_BITS),
        .K30       (acos_pkg::K30_C2)
    ) u_horner_c2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .o_ready (h_ready[0]),
        .i_coef  (C3),
        .i_a     (r_s0_a),
        .i_neg   (r_s0_neg),
        .o_valid (h_valid[0]),
        .i_ready (h_ready[1]),
        .o_acc   (h_acc[0]),
        .o_a     (h_a[0]),
        .o_neg   (h_neg[0])
    );

    acos_horner_cell #(
        .FRAC_BITS (FRAC_BITS),
        .K30       (acos_pkg::K30_C1)
    ) u_horner_c1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h_valid[0]),
        .o_ready (h_ready[1]),
        .i_coef  (h_acc[0]),
        .i_a     (h_a[0]),
        .i_neg   (h_neg[0]),
        .o_valid (h_valid[1]),
        .i_ready (h_ready[2]),
        .o_acc   (h_acc[1]),
        .o_a     (h_a[1]),
        .o_neg   (h_neg[1])
    );

    acos_horner_cell #(
        .FRAC_BITS (FRAC_BITS),
        .K30       (acos_pkg::K30_C0)
    ) u_horner_c0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h_valid[1]),
        .o_ready (h_ready[2]),
        .i_coef  (h_acc[1]),
        .i_a     (h_a[1]),
        .i_neg   (h_neg[1]),
        .o_valid (h_valid[2]),
        .i_ready (w_sq_ready[0]),
        .o_acc   (h_acc[2]),
        .o_a     (h_a[2]),
        .o_neg   (h_neg[2])
    );

    // ---------------- square root chain ----------------
    logic           w_sq_valid [NC+1];
    logic [N-1:0]   w_sq_rem   [NC+1];
    logic [N-1:0]   w_sq_root  [NC+1];
    logic [PW-1:0]  w_sq_pay   [NC+1];
    logic [W-1:0]   w_diff;
    logic           w_pr_take;

    // radicand (1 - a) << frac, payload carries sign and polynomial value
    assign w_diff        = ONE - h_a[2];
    assign w_sq_valid[0] = h_valid[2];
    assign w_sq_rem[0]   = {1'b0, w_diff, {FRAC_BITS{1'b0}}};
    assign w_sq_root[0]  = '0;
    assign w_sq_pay[0]   = {h_neg[2], h_acc[2]};

    genvar j;
    generate
        for (j = 0; j < NC; j++) begin : g_sqrt
            logic w_next_ready;
            if (j == NC - 1) begin : g_last
                assign w_next_ready = w_pr_take;
            end else begin : g_mid
                assign w_next_ready = w_sq_ready[j+1];
            end

            acos_sqrt_cell #(
                .FRAC_BITS (FRAC_BITS),
                .STEP      (FRAC_BITS - j),
                .PW        (PW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_sq_valid[j]),
                .o_ready (w_sq_ready[j]),
                .i_rem   (w_sq_rem[j]),
                .i_root  (w_sq_root[j]),
                .i_pay   (w_sq_pay[j]),
                .o_valid (w_sq_valid[j+1]),
                .i_ready (w_next_ready),
                .o_rem   (w_sq_rem[j+1]),
                .o_root  (w_sq_root[j+1]),
                .o_pay   (w_sq_pay[j+1])
            );
        end
    endgenerate

    // ---------------- product stage ----------------
    logic           r_pr_valid;
    logic [W-1:0]   r_pr_r;
    logic           r_pr_neg;

    logic [W-1:0]   w_root;
    logic [W-1:0]   w_poly;
    logic [2*W-1:0] w_prod;
    logic [2*W:0]   w_psum;
    logic [W-1:0]   n_pr_r;
    logic           w_out_take;

    // polynomial times square root, rounded
    assign w_root = w_sq_root[NC][W-1:0];
    assign w_poly = w_sq_pay[NC][W-1:0];
    assign w_prod = w_poly * w_root;
    assign w_psum = {1'b0, w_prod} + HALF;
    assign n_pr_r = w_psum[FRAC_BITS+W-1:FRAC_BITS];

    assign w_pr_take = !r_pr_valid || w_out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_valid <= 1'b0;
        end else if (w_pr_take) begin
            r_pr_valid <= w_sq_valid[NC];
        end
        if (w_pr_take && w_sq_valid[NC]) begin
            r_pr_r   <= n_pr_r;
            r_pr_neg <= w_sq_pay[NC][PW-1];
        end
    end

    // ---------------- output stage ----------------
    logic           r_out_valid;
    logic [15:0]    r_angle;
    logic [W:0]     w_refl;
    logic [15:0]    n_angle;

    // reflect negative inputs to pi minus the angle
    assign w_refl = r_pr_neg ? (PI - {1'b0, r_pr_r}) : {1'b0, r_pr_r};

    // back to q2.14
    generate
        if (FRAC_BITS > acos_pkg::IO_FRAC) begin : g_round
            localparam int SH = FRAC_BITS - acos_pkg::IO_FRAC;
            logic [W+1:0] w_rsum;
            assign w_rsum  = {1'b0, w_refl} + ((W+2)'(1) << (SH - 1));
            assign n_angle = w_rsum[SH+15:SH];
        end else if (FRAC_BITS == acos_pkg::IO_FRAC) begin : g_keep
            assign n_angle = w_refl;
        end else begin : g_shift
            assign n_angle = {w_refl, {(acos_pkg::IO_FRAC - FRAC_BITS){1'b0}}};
        end
    endgenerate

    assign w_out_take = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_take) begin
            r_out_valid <= r_pr_valid;
        end
        if (w_out_take && r_pr_valid) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_out_valid;
    assign o_angle = r_angle;

`ifndef SYNTH
    // an input transfer always lands in the input register
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s0_valid)
        else $error("input transfer lost at input stage");

    // saturated magnitude never exceeds one
    a_mag_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_valid |-> (r_s0_a <= ONE))
        else $error("magnitude above one after saturation");

    // square root of a value at most one is at most one
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_valid[NC] |-> (w_sq_root[NC] <= N'(ONE)))
        else $error("square root out of range");

    // a blocked output keeps the product stage occupied
    a_pr_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && r_pr_valid) |=> (r_pr_valid && $stable(r_pr_r)))
        else $error("product stage changed under stall");
`endif

endmodule

`default_nettype wire

/* rtl/acos_horner_cell.sv */
// one horner step: acc = k - round(coef * a), with its own pipeline register
`default_nettype none

module acos_horner_cell #(
    parameter int          FRAC_BITS = acos_pkg::FRAC_BITS_DEF,
    parameter logic [63:0] K30       = acos_pkg::K30_C2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [FRAC_BITS:0]   i_coef,
    input  wire logic [FRAC_BITS:0]   i_a,
    input  wire logic                 i_neg,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [FRAC_BITS:0]   o_acc,
    output logic      [FRAC_BITS:0]   o_a,
    output logic                      o_neg
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0]   K    = W'(acos_pkg::to_frac(K30, FRAC_BITS));
    localparam logic [2*W:0]   HALF = (2*W+1)'(1) << (FRAC_BITS - 1);

    logic             r_valid;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic             r_neg;

    logic [2*W-1:0]   w_prod;
    logic [2*W:0]     w_sum;
    logic [W-1:0]     w_q;
    logic [W-1:0]     n_acc;

    // rounded fixed-point product and subtract from the coefficient
    assign w_prod = i_coef * i_a;
    assign w_sum  = {1'b0, w_prod} + HALF;
    assign w_q    = w_sum[FRAC_BITS+W-1:FRAC_BITS];
    assign n_acc  = K - w_q;

    // cell takes a new transfer when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    // pipeline register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_acc <= n_acc;
            r_a   <= i_a;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_a     = r_a;
    assign o_neg   = r_neg;

endmodule

`default_nettype wire

/* rtl/acos_sqrt_cell.sv */
// one digit of the restoring integer square root, with a side payload carried along
`default_nettype none

module acos_sqrt_cell #(
    parameter int FRAC_BITS = acos_pkg::FRAC_BITS_DEF,
    parameter int STEP      = 0,
    parameter int PW        = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [2*FRAC_BITS+1:0]    i_rem,
    input  wire logic [2*FRAC_BITS+1:0]    i_root,
    input  wire logic [PW-1:0]             i_pay,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic      [2*FRAC_BITS+1:0]    o_rem,
    output logic      [2*FRAC_BITS+1:0]    o_root,
    output logic      [PW-1:0]             o_pay
);

    localparam int N = 2*FRAC_BITS + 2;
    localparam logic [N-1:0] BIT = N'(1) << (2*STEP);

    logic           r_valid;
    logic [N-1:0]   r_rem;
    logic [N-1:0]   r_root;
    logic [PW-1:0]  r_pay;

    logic [N-1:0]   w_trial;
    logic           w_ge;
    logic [N-1:0]   n_rem;
    logic [N-1:0]   n_root;

    // trial subtract of the current root digit
    assign w_trial = i_root + BIT;
    assign w_ge    = (i_rem >= w_trial);
    assign n_rem   = w_ge ? (i_rem - w_trial) : i_rem;
    assign n_root  = w_ge ? ((i_root >> 1) + BIT) : (i_root >> 1);

    assign o_ready = !r_valid || i_ready;

    // pipeline register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_pay   = r_pay;

endmodule

`default_nettype wire
